// ===== hw/rtl/timestamp_ordered_queue_unit_assert.svh =====
// Assertion macros for the queue RTL.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef TIMESTAMP_ORDERED_QUEUE_UNIT_ASSERT_SVH
`define TIMESTAMP_ORDERED_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in timestamp queue");

// The consequent must hold in the cycle after the antecedent.
`define TSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in timestamp queue");

`endif

// ===== hw/rtl/tsq_pkg.sv =====
`default_nettype none

package tsq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned SecW          = 32;
  localparam int unsigned NsecW         = 30;
  localparam int unsigned KeyW          = SecW + NsecW;
  localparam int unsigned HandleW       = 32;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned FillW         = 5;
  localparam int unsigned InDataW       = 96;
  localparam int unsigned OutDataW      = 40;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } cmd_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic               valid;
    logic               later;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/timestamp_ordered_queue_unit.sv =====
// Channel   Direction  Bus           Beat contents
// s_axis    in         tdata [95:0]  time_sec, time_nsec, handle
//                      tuser [0:0]   op
// m_axis    out        tdata [39:0]  out_handle, fill_count
//                      tuser [1:0]   status
//
// One beat is taken per cycle while m_axis is not stalled; its result appears on m_axis in the next cycle.
// Each operation is done by the cell chain: every cell compares its stored key
// against the new key at once, then shifts toward the tail or head.
// rst_ni (asynchronous, active low) empties the queue and the output register.
// A result held on m_axis stalls s_axis only while m_axis_tready is low.

`default_nettype none

module timestamp_ordered_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = tsq_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0 up: time_sec[31:0], time_nsec[61:32], handle[93:62], zero pad.
  input  logic [tsq_pkg::InDataW-1:0]    s_axis_tdata,
  // Fields from bit 0 up: op (0 enqueue, 1 dequeue).
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: out_handle[31:0], fill_count[36:32], zero pad.
  output logic [tsq_pkg::OutDataW-1:0]   m_axis_tdata,
  // Fields from bit 0 up: status (0 ok, 1 full, 2 empty).
  output logic [tsq_pkg::StatusW-1:0]    m_axis_tuser
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic                              accept;
  logic                              is_deq;
  logic                              full;
  logic                              empty;
  logic                              empty_deq;
  logic [CntW-1:0]                   count_q, count_d;
  tsq_pkg::cmd_t                     cmd;
  tsq_pkg::entry_t                   cells  [QUEUE_DEPTH];
  tsq_pkg::entry_t                   prev_in[QUEUE_DEPTH];
  tsq_pkg::entry_t                   next_in[QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]            valid_vec;

  logic                              out_valid_q;
  logic [tsq_pkg::StatusW-1:0]       out_status_q, out_status_d;
  logic [tsq_pkg::HandleW-1:0]       out_handle_q, out_handle_d;
  logic [tsq_pkg::FillW-1:0]         out_fill_q;

  // The output register frees up in the same cycle it is drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_deq        = (s_axis_tuser == tsq_pkg::OP_DEQ);
  assign full          = (count_q == CntW'(QUEUE_DEPTH));
  assign empty         = (count_q == '0);
  assign empty_deq     = accept && is_deq && empty;

  // A rejected enqueue or an empty dequeue leaves the chain untouched.
  assign cmd.enq    = accept && !is_deq && !full;
  assign cmd.deq    = accept && is_deq && !empty;
  assign cmd.key    = {s_axis_tdata[31:0], s_axis_tdata[61:32]};
  assign cmd.handle = s_axis_tdata[93:62];

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  // The head sees a virtual valid entry that is never later, so it only takes
  // the new key; the tail sees an empty neighbor when the queue shifts forward.
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_in[gi] = '{valid: 1'b1, later: 1'b0, key: '0, handle: '0};
      end else begin : g_mid
        assign prev_in[gi] = cells[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign next_in[gi] = '{valid: 1'b0, later: 1'b1, key: '0, handle: '0};
      end else begin : g_body
        assign next_in[gi] = cells[gi+1];
      end

      tsq_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd),
        .prev_i (prev_in[gi]),
        .next_i (next_in[gi]),
        .cell_o (cells[gi])
      );

      assign valid_vec[gi] = cells[gi].valid;
    end
  endgenerate

  // Result of the beat being accepted; the handle is the head only on a good dequeue.
  always_comb begin
    out_status_d = tsq_pkg::ST_OK;
    out_handle_d = '0;
    if (is_deq) begin
      if (empty) begin
        out_status_d = tsq_pkg::ST_EMPTY;
      end else begin
        out_handle_d = cells[0].handle;
      end
    end else if (full) begin
      out_status_d = tsq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= out_status_d;
      out_handle_q <= out_handle_d;
      out_fill_q   <= tsq_pkg::FillW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_fill_q, out_handle_q};

`include "timestamp_ordered_queue_unit_assert.svh"

  // The count never runs past the number of cells.
  `TSQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(QUEUE_DEPTH))
  // Occupied cells always number exactly the entry count.
  `TSQ_ASSERT_IMPL(a_valid_matches_count, 1'b1, $countones(valid_vec) == 32'(count_q))
  // The head never holds a later key than the cell behind it.
  `TSQ_ASSERT_IMPL(a_head_sorted, cells[1].valid, !(cells[0].key > cells[1].key))
  // A dequeue of an empty queue reports empty with a zero handle.
  `TSQ_ASSERT_NEXT(a_empty_deq, empty_deq, out_status_q == tsq_pkg::ST_EMPTY && out_handle_q == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_cell.sv =====
`default_nettype none

module tsq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsq_pkg::cmd_t   cmd_i,
  input  tsq_pkg::entry_t prev_i,
  input  tsq_pkg::entry_t next_i,
  output tsq_pkg::entry_t cell_o
);

  logic                        valid_q, valid_d;
  logic [tsq_pkg::KeyW-1:0]    key_q, key_d;
  logic [tsq_pkg::HandleW-1:0] handle_q, handle_d;
  logic                        later;

  // An empty cell counts as later than any key, so a new entry with no later stored key lands behind the last entry.
  assign later = !valid_q || (key_q > cmd_i.key);

  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    handle_d = handle_q;
    if (cmd_i.enq) begin
      valid_d = valid_q | prev_i.valid;
      if (prev_i.later) begin
        key_d    = prev_i.key;
        handle_d = prev_i.handle;
      end else if (later) begin
        key_d    = cmd_i.key;
        handle_d = cmd_i.handle;
      end
    end else if (cmd_i.deq) begin
      valid_d  = next_i.valid;
      key_d    = next_i.key;
      handle_d = next_i.handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign cell_o.valid  = valid_q;
  assign cell_o.later  = later;
  assign cell_o.key    = key_q;
  assign cell_o.handle = handle_q;

endmodule

`default_nettype wire
